>>> design/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types, codes and constants of the histogram with running statistics.
// ----------------------------------------------------------------------------
package hrs_pkg;

    // default sizing of the bin store
    localparam int NUM_BINS_DEF    = 256;
    localparam int BIN_COUNT_W_DEF = 32;

    // divider width: a non-negative Q16.16 sample and the bin width are 31 bits
    localparam int DIV_W     = 31;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THR  = 1'd1;

    localparam logic [30:0] BIN_WIDTH_RST = 31'd65536;
    localparam logic [15:0] ZERO_THR_RST  = 16'd1;

    // command opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NEG    = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic signed [31:0] sample;
        logic [7:0]        bin_index;
    } t_hrs_in;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [8:0]  bins_used;
        logic [39:0] value_count;
        logic [39:0] zero_count;
        logic [62:0] value_sum;
        logic [62:0] square_sum;
        logic [30:0] min_value;
        logic [30:0] max_value;
        logic [1:0]  status;
    } t_hrs_out;

    // running statistics handed from the statistics unit to the top level
    typedef struct packed {
        logic [39:0] value_count;
        logic [39:0] zero_count;
        logic [62:0] value_sum;
        logic [62:0] square_sum;
        logic [30:0] min_value;
        logic [30:0] max_value;
    } t_hrs_stats;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SQ,
        S_DIV,
        S_RD,
        S_WR,
        S_STAT,
        S_RDMEM,
        S_FINISH
    } t_hrs_state;

endpackage

>>> design/hrs_div.sv
// ----------------------------------------------------------------------------
// hrs_div
// Radix-2 restoring divider, one quotient bit per cycle. A zero divisor
// yields an all-ones quotient.
// ----------------------------------------------------------------------------
module hrs_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [hrs_pkg::DIV_W-1:0] i_dividend,
    input  logic [hrs_pkg::DIV_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [hrs_pkg::DIV_W-1:0] o_quotient
);

    logic [hrs_pkg::DIV_W-1:0]     r_dvd;
    logic [hrs_pkg::DIV_W-1:0]     r_rem;
    logic [hrs_pkg::DIV_W-1:0]     r_dvs;
    logic [hrs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_run;
    logic                          r_done;

    logic [hrs_pkg::DIV_W:0]   rem_sh;
    logic [hrs_pkg::DIV_W+1:0] diff;
    logic                      ge;

    // shift in next dividend bit and trial subtract
    assign rem_sh = {r_rem, r_dvd[hrs_pkg::DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign ge     = ~diff[hrs_pkg::DIV_W+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= hrs_pkg::DIV_CNT_W'(hrs_pkg::DIV_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits replace dividend bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[hrs_pkg::DIV_W-2:0], ge};
            r_rem <= ge ? diff[hrs_pkg::DIV_W-1:0] : rem_sh[hrs_pkg::DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

>>> design/hrs_stats.sv
// ----------------------------------------------------------------------------
// hrs_stats
// Running statistics: saturating count, zero count, sum, sum of squares,
// minimum and maximum. The square is registered before it is accumulated.
// ----------------------------------------------------------------------------
module hrs_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [30:0]         i_sample,
    input  logic                i_apply,
    input  logic                i_zero,
    output hrs_pkg::t_hrs_stats o_stats
);

    logic [45:0] r_sq;
    logic [39:0] r_count;
    logic [39:0] r_zeros;
    logic [62:0] r_sum;
    logic [62:0] r_sqsum;
    logic [30:0] r_min;
    logic [30:0] r_max;

    logic [61:0] sq_full;
    logic [63:0] sum_next;
    logic [63:0] sqsum_next;

    // square, truncated to Q30.16
    assign sq_full = 62'(i_sample) * 62'(i_sample);

    always_ff @(posedge i_clk) begin
        r_sq <= sq_full[61:16];
    end

    assign sum_next   = 64'(r_sum) + 64'(i_sample);
    assign sqsum_next = 64'(r_sqsum) + 64'(r_sq);

    // accumulate on apply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_zeros <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else if (i_apply) begin
            if (r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
            if (i_zero && (r_zeros != '1)) begin
                r_zeros <= r_zeros + 1'b1;
            end
            r_sum   <= sum_next[63] ? '1 : sum_next[62:0];
            r_sqsum <= sqsum_next[63] ? '1 : sqsum_next[62:0];
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
        end
    end

    assign o_stats.value_count = r_count;
    assign o_stats.zero_count  = r_zeros;
    assign o_stats.value_sum   = r_sum;
    assign o_stats.square_sum  = r_sqsum;
    assign o_stats.min_value   = r_min;
    assign o_stats.max_value   = r_max;

endmodule

>>> design/histogram_with_running_stats.sv
// ----------------------------------------------------------------------------
// histogram_with_running_stats
// Streaming histogram of Q16.16 samples with saturating running statistics.
// Adds bin a sample at floor(sample / bin_width) with a shared serial divider;
// reads return one bin count. Every command returns one result word.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  command   | i_start, o_busy, i_cmd                    | in
//  result    | o_done, o_result                          | out
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data | in
//
//  A binned sample runs through the 31-step serial divider and, if it falls
//  in a bin, the read-modify-write of the bin store; reads, negative samples
//  and samples below the zero threshold do not use the divider.
//  After reset the bin store is cleared, one entry a cycle, with o_busy
//  high. Config writes are taken in every cycle.
//  The receiver cannot stall: o_done marks a result word for one cycle.
// ----------------------------------------------------------------------------
module histogram_with_running_stats #(
    parameter int NUM_BINS        = hrs_pkg::NUM_BINS_DEF,
    parameter int BIN_COUNT_WIDTH = hrs_pkg::BIN_COUNT_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  hrs_pkg::t_hrs_in                i_cmd,
    output logic                            o_busy,
    output logic                            o_done,
    output hrs_pkg::t_hrs_out               o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hrs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int BIN_IDX_W = $clog2(NUM_BINS);
    localparam int USED_W    = $clog2(NUM_BINS + 1);

    hrs_pkg::t_hrs_state r_state, n_state;

    logic [30:0]                r_bin_width;
    logic [15:0]                r_zero_thr;
    logic                       r_op;
    logic [30:0]                r_sample;
    logic [7:0]                 r_index;
    logic                       r_zero;
    logic [1:0]                 r_status;
    logic [BIN_COUNT_WIDTH-1:0] r_count;
    logic [BIN_IDX_W-1:0]       r_bin;
    logic [BIN_IDX_W-1:0]       r_clr_addr;
    logic [USED_W-1:0]          r_used;
    logic [BIN_COUNT_WIDTH-1:0] r_rd_data;

    logic [BIN_COUNT_WIDTH-1:0] mem [NUM_BINS];

    logic                       accept;
    logic                       is_neg;
    logic                       is_zero;
    logic                       div_start;
    logic                       div_done;
    logic [hrs_pkg::DIV_W-1:0]  div_quo;
    logic                       in_range;
    logic                       stats_apply;
    logic                       finish;
    logic                       mem_we;
    logic                       mem_re;
    logic [BIN_IDX_W-1:0]       mem_addr;
    logic [BIN_COUNT_WIDTH-1:0] mem_wdata;
    logic [BIN_COUNT_WIDTH-1:0] inc_count;
    logic [USED_W:0]            hit_used;
    logic                       read_ok;
    logic [BIN_COUNT_WIDTH-1:0] out_count;
    hrs_pkg::t_hrs_stats        stats;

    // command decode
    assign o_busy      = (r_state != hrs_pkg::S_IDLE);
    assign accept      = i_start && !o_busy;
    assign is_neg      = i_cmd.sample[31];
    assign is_zero     = (i_cmd.sample[31:0] < 32'(r_zero_thr));
    assign in_range    = (32'(div_quo) < 32'(NUM_BINS));
    assign inc_count   = (r_rd_data == '1) ? r_rd_data : r_rd_data + 1'b1;
    assign hit_used    = (USED_W + 1)'(r_bin) + 1'b1;
    assign read_ok     = (32'(r_index) < 32'(r_used)) && (32'(r_index) < 32'(NUM_BINS));
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= hrs_pkg::BIN_WIDTH_RST;
            r_zero_thr  <= hrs_pkg::ZERO_THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hrs_pkg::CFG_BIN_WIDTH: begin
                    r_bin_width <= i_cfg_data[30:0];
                end
                hrs_pkg::CFG_ZERO_THR: begin
                    r_zero_thr <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hrs_pkg::S_CLEAR: begin
                if (r_clr_addr == BIN_IDX_W'(NUM_BINS - 1)) begin
                    n_state = hrs_pkg::S_IDLE;
                end
            end
            hrs_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd.opcode == hrs_pkg::OP_READ) begin
                        n_state = hrs_pkg::S_RDMEM;
                    end else if (is_neg) begin
                        n_state = hrs_pkg::S_FINISH;
                    end else if (is_zero) begin
                        n_state = hrs_pkg::S_SQ;
                    end else begin
                        n_state = hrs_pkg::S_DIV;
                    end
                end
            end
            hrs_pkg::S_SQ:    n_state = hrs_pkg::S_STAT;
            hrs_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = in_range ? hrs_pkg::S_RD : hrs_pkg::S_STAT;
                end
            end
            hrs_pkg::S_RD:     n_state = hrs_pkg::S_WR;
            hrs_pkg::S_WR:     n_state = hrs_pkg::S_STAT;
            hrs_pkg::S_STAT:   n_state = hrs_pkg::S_FINISH;
            hrs_pkg::S_RDMEM:  n_state = hrs_pkg::S_FINISH;
            hrs_pkg::S_FINISH: n_state = hrs_pkg::S_IDLE;
            default:           n_state = hrs_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        div_start   = 1'b0;
        stats_apply = 1'b0;
        finish      = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = r_bin;
        mem_wdata   = inc_count;
        case (r_state)
            hrs_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
            end
            hrs_pkg::S_IDLE: begin
                div_start = accept && (i_cmd.opcode == hrs_pkg::OP_ADD) && !is_neg
                            && !is_zero;
            end
            hrs_pkg::S_RD: begin
                mem_re = 1'b1;
            end
            hrs_pkg::S_WR: begin
                mem_we = 1'b1;
            end
            hrs_pkg::S_STAT: begin
                stats_apply = 1'b1;
            end
            hrs_pkg::S_RDMEM: begin
                mem_re   = 1'b1;
                mem_addr = BIN_IDX_W'(r_index);
            end
            hrs_pkg::S_FINISH: begin
                finish = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= hrs_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_used     <= '0;
            o_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= finish;
            if (r_state == hrs_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == hrs_pkg::S_WR) && (hit_used > (USED_W + 1)'(r_used))) begin
                r_used <= USED_W'(hit_used);
            end
        end
    end

    // command payload and per-command results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_cmd.opcode;
            r_sample <= i_cmd.sample[30:0];
            r_index  <= i_cmd.bin_index;
            r_zero   <= is_zero;
            r_count  <= '0;
            r_status <= is_neg ? hrs_pkg::ST_NEG : hrs_pkg::ST_OK;
        end
        if ((r_state == hrs_pkg::S_DIV) && div_done) begin
            r_bin <= BIN_IDX_W'(div_quo);
            if (!in_range) begin
                r_status <= hrs_pkg::ST_BEYOND;
            end
        end
        if (r_state == hrs_pkg::S_WR) begin
            r_count <= inc_count;
        end
    end

    // bin store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // result word
    assign out_count = (r_op == hrs_pkg::OP_READ) ? (read_ok ? r_rd_data : '0) : r_count;

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_result.bin_count   <= 32'(out_count);
            o_result.bins_used   <= 9'(r_used);
            o_result.value_count <= stats.value_count;
            o_result.zero_count  <= stats.zero_count;
            o_result.value_sum   <= stats.value_sum;
            o_result.square_sum  <= stats.square_sum;
            o_result.min_value   <= stats.min_value;
            o_result.max_value   <= stats.max_value;
            if (r_op == hrs_pkg::OP_READ) begin
                o_result.status <= read_ok ? hrs_pkg::ST_OK : hrs_pkg::ST_UNUSED;
            end else begin
                o_result.status <= r_status;
            end
        end
    end

    // shared serial divider
    hrs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cmd.sample[30:0]),
        .i_divisor  (r_bin_width),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // running statistics
    hrs_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (r_sample),
        .i_apply  (stats_apply),
        .i_zero   (r_zero),
        .o_stats  (stats)
    );

endmodule

>>> design/hrs_checker.sv
// ----------------------------------------------------------------------------
// hrs_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
module hrs_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_start,
    input logic                   i_busy,
    input logic                   i_done,
    input hrs_pkg::t_hrs_out      i_result
);

    // a result word ends the command, so the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> !i_busy)
        else $error("result word while busy");

    // an accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("block not busy after accepting a command");

    // one result word per command, never two in a row
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |=> !i_done)
        else $error("result strobe held for two cycles");

    // rejected samples and unused bins report no count
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && (i_result.status == hrs_pkg::ST_NEG
                    || i_result.status == hrs_pkg::ST_UNUSED
                    || i_result.status == hrs_pkg::ST_BEYOND))
        |-> (i_result.bin_count == '0))
        else $error("nonzero bin count with error status");

endmodule

bind histogram_with_running_stats hrs_checker u_hrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_busy   (o_busy),
    .i_done   (o_done),
    .i_result (o_result)
);

>>> test/histogram_with_running_stats_test.sv
// ----------------------------------------------------------------------------
// histogram_with_running_stats_test
// Self-checking bench for the streaming histogram with running statistics.
// A short table of directed commands and register settings runs first, then
// random adds and reads under several bin widths and zero thresholds. Every
// result word is compared field by field against an in-bench model of the
// bin store and the saturating statistics.
// ----------------------------------------------------------------------------
module histogram_with_running_stats_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MAX40 = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_WORDS   = 250;

    typedef enum logic {ROW_CMD, ROW_SET} t_row_kind;

    // one line of the directed table: a command word or a register setting
    typedef struct {
        t_row_kind        kind;
        hrs_pkg::t_hrs_in word;
        logic             typed;
        logic [31:0]      typed_count;
        logic [1:0]       typed_status;
        logic [31:0]      set_width;
        logic [31:0]      set_thr;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_start = 1'b0;
    hrs_pkg::t_hrs_in               i_cmd = '0;
    logic                           o_busy;
    logic                           o_done;
    hrs_pkg::t_hrs_out              o_result;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [hrs_pkg::CFG_IDX_W-1:0]  i_cfg_index = hrs_pkg::CFG_BIN_WIDTH;
    logic [hrs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // model of the block: bin store, statistics and registers
    logic [31:0] bin_tally [hrs_pkg::NUM_BINS_DEF];
    logic [8:0]  used_mark;
    logic [39:0] sample_tally;
    logic [39:0] zero_tally;
    logic [62:0] sum_acc;
    logic [62:0] square_acc;
    logic [30:0] low_mark;
    logic [30:0] high_mark;
    logic [30:0] width_cfg;
    logic [15:0] thr_cfg;

    hrs_pkg::t_hrs_out pending_results[$];
    t_row              stim_table[$];
    hrs_pkg::t_hrs_out due;
    int                mismatch_count = 0;
    bit                gaps_on = 1'b1;

    histogram_with_running_stats dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_cmd      (i_cmd),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] lim);
        if (a >= lim || b > lim - a) begin
            return lim;
        end
        return a + b;
    endfunction

    function automatic void reset_prediction();
        foreach (bin_tally[i]) begin
            bin_tally[i] = '0;
        end
        used_mark    = '0;
        sample_tally = '0;
        zero_tally   = '0;
        sum_acc      = '0;
        square_acc   = '0;
        low_mark     = '1;
        high_mark    = '0;
        width_cfg    = hrs_pkg::BIN_WIDTH_RST;
        thr_cfg      = hrs_pkg::ZERO_THR_RST;
    endfunction

    // expected result word of one command, advancing the model state
    function automatic hrs_pkg::t_hrs_out predict_histogram(hrs_pkg::t_hrs_in w);
        hrs_pkg::t_hrs_out r;
        logic [31:0]       raw;
        logic [31:0]       q;
        logic [63:0]       sq;
        r   = '0;
        raw = w.sample;
        if (w.opcode == hrs_pkg::OP_READ) begin
            if (9'(w.bin_index) < used_mark) begin
                r.bin_count = bin_tally[w.bin_index];
            end else begin
                r.status = hrs_pkg::ST_UNUSED;
            end
        end else if (raw[31]) begin
            r.status = hrs_pkg::ST_NEG;
        end else begin
            if (raw < 32'(thr_cfg)) begin
                zero_tally = 40'(clip_add(64'(zero_tally), 64'd1, MAX40));
            end else begin
                // a zero width divides to all ones, so it lands beyond the last bin
                q = (width_cfg == '0) ? '1 : raw / 32'(width_cfg);
                if (q < hrs_pkg::NUM_BINS_DEF) begin
                    bin_tally[q[7:0]] = 32'(clip_add(64'(bin_tally[q[7:0]]), 64'd1, MAX32));
                    r.bin_count = bin_tally[q[7:0]];
                    if (q + 32'd1 > 32'(used_mark)) begin
                        used_mark = 9'(q + 32'd1);
                    end
                end else begin
                    r.status = hrs_pkg::ST_BEYOND;
                end
            end
            sq           = (64'(raw) * 64'(raw)) >> 16;
            sum_acc      = 63'(clip_add(64'(sum_acc), 64'(raw), MAX63));
            square_acc   = 63'(clip_add(64'(square_acc), sq, MAX63));
            sample_tally = 40'(clip_add(64'(sample_tally), 64'd1, MAX40));
            if (raw[30:0] < low_mark) begin
                low_mark = raw[30:0];
            end
            if (raw[30:0] > high_mark) begin
                high_mark = raw[30:0];
            end
        end
        r.bins_used   = used_mark;
        r.value_count = sample_tally;
        r.zero_count  = zero_tally;
        r.value_sum   = sum_acc;
        r.square_sum  = square_acc;
        r.min_value   = low_mark;
        r.max_value   = high_mark;
        return r;
    endfunction

    function automatic void cmd_row(logic op, logic [31:0] smp, logic [7:0] idx,
                                    logic typed, logic [31:0] cnt, logic [1:0] st);
        t_row row;
        row.kind           = ROW_CMD;
        row.word.opcode    = op;
        row.word.sample    = smp;
        row.word.bin_index = idx;
        row.typed          = typed;
        row.typed_count    = cnt;
        row.typed_status   = st;
        row.set_width      = '0;
        row.set_thr        = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void set_row(logic [31:0] width_word, logic [31:0] thr_word);
        t_row row;
        row.kind         = ROW_SET;
        row.word         = '0;
        row.typed        = 1'b0;
        row.typed_count  = '0;
        row.typed_status = hrs_pkg::ST_OK;
        row.set_width    = width_word;
        row.set_thr      = thr_word;
        stim_table.push_back(row);
    endfunction

    // random command: mostly samples aimed at a chosen bin, plus noise
    function automatic hrs_pkg::t_hrs_in pick_word();
        hrs_pkg::t_hrs_in w;
        int unsigned      roll;
        int unsigned      k;
        logic [63:0]      base;
        w.opcode    = hrs_pkg::OP_ADD;
        w.sample    = $urandom;
        w.bin_index = 8'($urandom);
        roll        = $urandom_range(0, 99);
        if (roll < 10) begin
            w.sample[31] = 1'b1;
        end else if (roll < 20 && thr_cfg != '0) begin
            w.sample = $urandom_range(0, 32'(thr_cfg) - 1);
        end else if (roll < 32) begin
            w.opcode = hrs_pkg::OP_READ;
            if (used_mark != '0 && roll < 29) begin
                w.bin_index = 8'($urandom_range(0, 32'(used_mark) - 1));
            end
        end else if (roll < 40) begin
            w.sample[31] = 1'b0;
        end else begin
            k    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
            base = 64'(width_cfg) * 64'(k);
            if (width_cfg != '0 && base <= 64'h7FFF_FFFF) begin
                base     = base + 64'($urandom % 32'(width_cfg));
                w.sample = (base > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : base[31:0];
            end else begin
                w.sample[31] = 1'b0;
            end
        end
        return w;
    endfunction

    // present one command word and record its expected result on acceptance
    task automatic send_word(hrs_pkg::t_hrs_in w, logic typed, logic [31:0] cnt,
                             logic [1:0] st);
        hrs_pkg::t_hrs_out e;
        if (gaps_on && $urandom_range(0, 99) < 9) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= w;
        do @(posedge i_clk); while (o_busy);
        e = predict_histogram(w);
        if (typed) begin
            e.bin_count = cnt;
            e.status    = st;
        end
        pending_results.push_back(e);
    endtask

    // drain the block, then write both registers back to back
    task automatic apply_settings(logic [31:0] width_word, logic [31:0] thr_word);
        i_start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0 || o_busy);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= hrs_pkg::CFG_BIN_WIDTH;
        i_cfg_data  <= width_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        width_cfg = width_word[30:0];
        i_cfg_index <= hrs_pkg::CFG_ZERO_THR;
        i_cfg_data  <= thr_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        thr_cfg = thr_word[15:0];
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
        end
    endfunction

    // result word checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with none pending, expected none, got %0h",
                         $realtime, o_result);
            end else begin
                due = pending_results.pop_front();
                check_field("bin_count",   64'(due.bin_count),   64'(o_result.bin_count));
                check_field("bins_used",   64'(due.bins_used),   64'(o_result.bins_used));
                check_field("value_count", 64'(due.value_count), 64'(o_result.value_count));
                check_field("zero_count",  64'(due.zero_count),  64'(o_result.zero_count));
                check_field("value_sum",   64'(due.value_sum),   64'(o_result.value_sum));
                check_field("square_sum",  64'(due.square_sum),  64'(o_result.square_sum));
                check_field("min_value",   64'(due.min_value),   64'(o_result.min_value));
                check_field("max_value",   64'(due.max_value),   64'(o_result.max_value));
                check_field("status",      64'(due.status),      64'(o_result.status));
            end
        end
    end

    // main sequence
    initial begin
        t_row        row;
        logic [30:0] width_val;
        logic [15:0] thr_val;
        reset_prediction();

        // fresh store, default width 1.0 and threshold 1
        cmd_row(hrs_pkg::OP_READ, 32'h0,         8'd0,   1'b1, 32'd0, hrs_pkg::ST_UNUSED);
        cmd_row(hrs_pkg::OP_READ, 32'h0,         8'd255, 1'b1, 32'd0, hrs_pkg::ST_UNUSED);
        cmd_row(hrs_pkg::OP_ADD,  32'h8000_0000, 8'd0,   1'b1, 32'd0, hrs_pkg::ST_NEG);
        cmd_row(hrs_pkg::OP_ADD,  32'hFFFF_FFFF, 8'd255, 1'b1, 32'd0, hrs_pkg::ST_NEG);
        cmd_row(hrs_pkg::OP_ADD,  32'h0000_0000, 8'd0,   1'b1, 32'd0, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_ADD,  32'h0000_0001, 8'd0,   1'b1, 32'd1, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_ADD,  32'h0001_0000, 8'd0,   1'b1, 32'd1, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_ADD,  32'h00FF_0000, 8'd0,   1'b1, 32'd1, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_ADD,  32'h00FF_FFFF, 8'd0,   1'b1, 32'd2, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_ADD,  32'h0100_0000, 8'd0,   1'b1, 32'd0, hrs_pkg::ST_BEYOND);
        cmd_row(hrs_pkg::OP_ADD,  32'h7FFF_FFFF, 8'd0,   1'b1, 32'd0, hrs_pkg::ST_BEYOND);
        cmd_row(hrs_pkg::OP_READ, 32'hFFFF_FFFF, 8'd255, 1'b1, 32'd2, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_READ, 32'h0,         8'd0,   1'b1, 32'd1, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_READ, 32'h0,         8'd128, 1'b0, 32'd0, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_ADD,  32'h0001_8000, 8'd0,   1'b0, 32'd0, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_READ, 32'h0,         8'd1,   1'b0, 32'd0, hrs_pkg::ST_OK);
        // zero bin width sends every binned sample beyond the last bin
        set_row(32'h0000_0000, 32'h0000_0001);
        cmd_row(hrs_pkg::OP_ADD,  32'h0005_0000, 8'd0,   1'b1, 32'd0, hrs_pkg::ST_BEYOND);
        cmd_row(hrs_pkg::OP_ADD,  32'h0000_0000, 8'd0,   1'b1, 32'd0, hrs_pkg::ST_OK);
        // narrowest width, highest threshold
        set_row(32'h8000_0001, 32'hABCD_FFFF);
        cmd_row(hrs_pkg::OP_ADD,  32'h0000_FFFE, 8'd0,   1'b1, 32'd0, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_ADD,  32'h0000_FFFF, 8'd0,   1'b1, 32'd0, hrs_pkg::ST_BEYOND);
        // widest width, no zero threshold
        set_row(32'h7FFF_FFFF, 32'h0000_0000);
        cmd_row(hrs_pkg::OP_ADD,  32'h0000_0000, 8'd0,   1'b0, 32'd0, hrs_pkg::ST_OK);
        cmd_row(hrs_pkg::OP_ADD,  32'h7FFF_FFFF, 8'd0,   1'b0, 32'd0, hrs_pkg::ST_OK);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.kind == ROW_SET) begin
                apply_settings(row.set_width, row.set_thr);
            end else begin
                send_word(row.word, row.typed, row.typed_count, row.typed_status);
            end
        end

        // random phases, one register setting each
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    width_val = hrs_pkg::BIN_WIDTH_RST;
                    thr_val   = hrs_pkg::ZERO_THR_RST;
                end
                1: begin
                    width_val = 31'd1;
                    thr_val   = 16'd0;
                end
                2: begin
                    width_val = 31'h7FFF_FFFF;
                    thr_val   = 16'hFFFF;
                end
                3: begin
                    width_val = 31'($urandom_range(1, 32'h0100_0000));
                    thr_val   = 16'($urandom);
                end
                4: begin
                    width_val = 31'd0;
                    thr_val   = 16'($urandom_range(0, 255));
                end
                5: begin
                    width_val = 31'($urandom_range(16, 4096));
                    thr_val   = 16'($urandom_range(0, 15));
                end
                default: begin
                    width_val = 31'($urandom);
                    thr_val   = 16'($urandom);
                end
            endcase
            apply_settings({1'($urandom), width_val}, {16'($urandom), thr_val});
            // one phase runs with no gaps at all
            gaps_on = (p != 3);
            repeat (PHASE_WORDS) send_word(pick_word(), 1'b0, 32'd0, hrs_pkg::ST_OK);
        end

        i_start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("histogram_with_running_stats_test: done, clean");
        end else begin
            $display("histogram_with_running_stats_test: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("histogram_with_running_stats_test: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
design/hrs_pkg.sv
design/hrs_div.sv
design/hrs_stats.sv
design/histogram_with_running_stats.sv
design/hrs_checker.sv
test/histogram_with_running_stats_test.sv
